### rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, sizes and codes for the bounded deque with match count.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Ring size and word width
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_COUNT      = 3'd4
  } bdq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } bdq_status_t;

  typedef struct packed {
    logic [2:0]                   op;
    logic signed [DATA_WIDTH-1:0] value_in;
  } bdq_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_out;
    logic [CNT_W-1:0]             match_count;
    logic [CNT_W-1:0]             fill_level;
    logic [1:0]                   status;
  } bdq_out_t;

  // Ring position: (base + off) wrapped into the ring
  function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### rtl/core/bounded_deque_with_match_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_match_count
// Bounded double-ended queue of signed words in a RAM ring, with a match counter.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_ready  | in_data  (bdq_in_t)
//   out     | output    | out_valid / out_ready| out_data (bdq_out_t)
//
// Steps: a push writes the RAM and posts; a pop reads the RAM, then posts; a count
// reads one RAM word per stored entry, then posts. Unused op codes and rejected
// pushes or pops go straight to posting. One beat is worked on at a time.
// Reset: synchronous, active low; clears front index, fill count and control.
// The RAM is not cleared; only pushed entries are ever read.
// Stalls: a finished result waits in its own register while a new beat is taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_match_count
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bdq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bdq_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  state_t                  st_r, st_nxt;
  logic [ADDR_W-1:0]       front_r, front_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        match_r, match_nxt;
  logic [DATA_WIDTH-1:0]   value_r, value_nxt;
  bdq_out_t                res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  bdq_out_t                out_data_r, out_data_nxt;

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [DATA_WIDTH-1:0]   rd_data;
  logic                    in_fire;
  logic                    out_free;
  logic                    is_full;
  logic                    is_empty;
  logic [ADDR_W-1:0]       front_dec;
  logic [CNT_W-1:0]        match_sum;

  // Entry storage
  bdq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_WIDTH),
    .ADDR_P  (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (st_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_full   = (fill_r >= CNT_W'(DEPTH));
  assign is_empty  = (fill_r == '0);
  assign front_dec = (front_r == '0) ? ADDR_W'(DEPTH - 1) : front_r - 1'b1;
  assign match_sum = match_r + CNT_W'(rd_data == value_r);

  // Sequence one beat: decode, RAM access, scan, post result
  always_comb begin
    st_nxt    = st_r;
    front_nxt = front_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    match_nxt = match_r;
    value_nxt = value_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.value_out   = '0;
          res_nxt.match_count = '0;
          res_nxt.fill_level  = fill_r;
          res_nxt.status      = STAT_OK;
          st_nxt              = S_POST;
          unique case (in_data.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                wr_en              = 1'b1;
                wr_addr            = front_dec;
                front_nxt          = front_dec;
                fill_nxt           = fill_r + 1'b1;
                res_nxt.fill_level = fill_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                wr_en              = 1'b1;
                wr_addr            = ring_pos(front_r, fill_r);
                fill_nxt           = fill_r + 1'b1;
                res_nxt.fill_level = fill_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_nxt.status = STAT_EMPTY;
              end else begin
                rd_en              = 1'b1;
                rd_addr            = front_r;
                front_nxt          = ring_pos(front_r, CNT_W'(1));
                fill_nxt           = fill_r - 1'b1;
                res_nxt.fill_level = fill_r - 1'b1;
                st_nxt             = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_nxt.status = STAT_EMPTY;
              end else begin
                rd_en              = 1'b1;
                rd_addr            = ring_pos(front_r, fill_r - 1'b1);
                fill_nxt           = fill_r - 1'b1;
                res_nxt.fill_level = fill_r - 1'b1;
                st_nxt             = S_READ;
              end
            end
            OP_COUNT: begin
              value_nxt = in_data.value_in;
              if (!is_empty) begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                idx_nxt   = CNT_W'(1);
                match_nxt = '0;
                st_nxt    = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.value_out = rd_data;
        st_nxt            = S_POST;
      end
      S_SCAN: begin
        // Compare the word just read, then fetch the next one until all are scanned
        if (idx_r == fill_r) begin
          res_nxt.match_count = match_sum;
          st_nxt              = S_POST;
        end else begin
          match_nxt = match_sum;
          rd_en     = 1'b1;
          rd_addr   = ring_pos(front_r, idx_r);
          idx_nxt   = idx_r + 1'b1;
        end
      end
      S_POST: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load the posted result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (st_r == S_POST && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      front_r     <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      front_r     <= front_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/bdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_P  = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_P-1:0]  wr_addr,
  input  logic [WIDTH_P-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_P-1:0]  rd_addr,
  output logic [WIDTH_P-1:0] rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque with match count. A driver feeds
// command beats from a queue, a shadow deque predicts every response, and a
// monitor compares each response field by field. Traffic runs in three phases
// of differing idle rates, with one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top
  import bdq_pkg::*;
();

  // Unused op codes: the block must leave the queue alone
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT        = 420;
  localparam int HOLD_LEN       = 200;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RAND_PER_PHASE = 173;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bdq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bdq_out_t out_data;

  // Command beats waiting to be driven, responses waiting to arrive
  bdq_in_t  cmd_q[$];
  bdq_out_t resp_q[$];

  int queued_items   = 0;
  int accepted_items = 0;
  int resps_seen     = 0;
  int mismatches     = 0;
  int send_idle_pct  = 12;
  int recv_idle_pct  = 50;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  bit finishing      = 1'b0;
  int idle_cycles    = 0;

  // Shadow copy of the deque
  logic [DATA_WIDTH-1:0] shadow_ring[DEPTH];
  int                    shadow_head = 0;
  int                    shadow_fill = 0;

  bounded_deque_with_match_count u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Apply one command to the shadow deque and return the response it should give
  function automatic bdq_out_t deque_apply(input bdq_in_t cmd);
    bdq_out_t r;
    int       k;
    int       hits;
    r    = '0;
    hits = 0;
    r.status = STAT_OK;
    case (cmd.op)
      OP_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
          shadow_ring[shadow_head] = cmd.value_in;
          shadow_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_ring[(shadow_head + shadow_fill) % DEPTH] = cmd.value_in;
          shadow_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value_out = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value_out = shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH];
          shadow_fill--;
        end
      end
      OP_COUNT: begin
        for (k = 0; k < shadow_fill; k++) begin
          if (shadow_ring[(shadow_head + k) % DEPTH] == cmd.value_in) begin
            hits++;
          end
        end
        r.match_count = CNT_W'(hits);
      end
      default: begin
      end
    endcase
    r.fill_level = CNT_W'(shadow_fill);
    return r;
  endfunction

  // Driver: take accepted beats into the shadow deque, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resp_q.push_back(deque_apply(in_data));
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input bit unexpected, input bdq_out_t want,
                                 input bdq_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected) begin
        $display("mismatch: unexpected response value=%0d count=%0d fill=%0d status=%0d",
                 got.value_out, got.match_count, got.fill_level, got.status);
      end else begin
        $display("mismatch at response %0d: expected value=%0d count=%0d fill=%0d status=%0d",
                 resps_seen, want.value_out, want.match_count, want.fill_level,
                 want.status);
        $display("                          actual   value=%0d count=%0d fill=%0d status=%0d",
                 got.value_out, got.match_count, got.fill_level, got.status);
      end
    end
  endtask

  // Monitor: check each response beat, then decide ready for the next cycle
  always @(posedge clk) begin
    bdq_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        resps_seen++;
        if (resp_q.size() == 0) begin
          report_mismatch(1'b1, '0, out_data);
        end else begin
          want = resp_q.pop_front();
          if (out_data.value_out !== want.value_out ||
              out_data.match_count !== want.match_count ||
              out_data.fill_level !== want.fill_level ||
              out_data.status !== want.status) begin
            report_mismatch(1'b0, want, out_data);
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (!hold_done && resps_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst_n && !finishing) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [DATA_WIDTH-1:0] word);
    bdq_in_t cmd;
    cmd.op       = op;
    cmd.value_in = word;
    cmd_q.push_back(cmd);
    queued_items++;
  endtask

  function automatic logic [2:0] rand_push();
    return ($urandom_range(1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic logic [2:0] rand_pop();
    return ($urandom_range(1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  function automatic logic [2:0] rand_spare();
    case ($urandom_range(2))
      0:       return OP_SPARE_5;
      1:       return OP_SPARE_6;
      default: return OP_SPARE_7;
    endcase
  endfunction

  // Mostly a small pool of words so counts find matches, plus full-range words
  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4, 5:    return DATA_WIDTH'($urandom_range(1, 3));
      default: return $urandom;
    endcase
  endfunction

  // Random traffic in bursts: fill runs, drain runs, mixed and count-heavy runs
  task automatic queue_random(input int n);
    int                    made;
    int                    len;
    int                    mode;
    int                    j;
    int                    pct;
    logic [DATA_WIDTH-1:0] fill_word;
    made = 0;
    while (made < n) begin
      mode      = $urandom_range(4);
      len       = $urandom_range(4, 24);
      fill_word = pick_word();
      for (j = 0; j < len && made < n; j++) begin
        pct = $urandom_range(99);
        if (pct < 3) begin
          queue_cmd(rand_spare(), $urandom);
        end else begin
          case (mode)
            0: begin
              if (pct < 80) queue_cmd(rand_push(), pick_word());
              else if (pct < 90) queue_cmd(rand_pop(), $urandom);
              else queue_cmd(OP_COUNT, pick_word());
            end
            1: begin
              if (pct < 80) queue_cmd(rand_pop(), $urandom);
              else if (pct < 90) queue_cmd(rand_push(), pick_word());
              else queue_cmd(OP_COUNT, pick_word());
            end
            2: begin
              if (pct < 35) queue_cmd(rand_push(), pick_word());
              else if (pct < 70) queue_cmd(rand_pop(), $urandom);
              else queue_cmd(OP_COUNT, pick_word());
            end
            3: begin
              if (pct < 88) queue_cmd(rand_push(), fill_word);
              else queue_cmd(OP_COUNT, fill_word);
            end
            default: begin
              if (pct < 60) queue_cmd(OP_COUNT, pick_word());
              else if (pct < 80) queue_cmd(rand_push(), pick_word());
              else queue_cmd(rand_pop(), $urandom);
            end
          endcase
        end
        made++;
      end
    end
  endtask

  // Wait until every queued beat is accepted and every response is back
  task automatic wait_drained();
    while (!(accepted_items == queued_items && resp_q.size() == 0)) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int k;

    // Directed: empty pops and count, spare ops, extreme words
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_POP_BACK, '1);
    queue_cmd(OP_COUNT, '0);
    queue_cmd(OP_SPARE_5, 32'h5555_5555);
    queue_cmd(OP_SPARE_6, 32'hAAAA_AAAA);
    queue_cmd(OP_SPARE_7, '1);
    queue_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_cmd(OP_PUSH_BACK, 32'h8000_0000);
    queue_cmd(OP_PUSH_FRONT, '0);
    queue_cmd(OP_PUSH_BACK, '1);
    queue_cmd(OP_COUNT, 32'h7FFF_FFFF);
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_POP_BACK, '0);
    // Fill to the brim from both ends, then push into a full deque
    for (k = 0; k < DEPTH - 2; k++) begin
      queue_cmd((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'd5);
    end
    queue_cmd(OP_PUSH_BACK, 32'd9);
    queue_cmd(OP_PUSH_FRONT, 32'd9);
    queue_cmd(OP_COUNT, 32'd5);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily
    queue_random(RAND_PER_PHASE);
    wait_drained();

    // Phase two: the other way round
    send_idle_pct = 50;
    recv_idle_pct = 12;
    queue_random(RAND_PER_PHASE);
    wait_drained();

    // Phase three: no idling; the long hold-off lands here
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RAND_PER_PHASE);
    wait_drained();

    finishing = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && resp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
